// ===== design/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/mrfb_pkg.sv =====
`timescale 1ns / 1ps

package mrfb_pkg;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 48;
    localparam int ID_W       = 32;
    localparam int DATA_MAX   = 7;
    localparam int IDX_W      = 5;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_METER_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_BROADCAST = 2'd1;

    // frame bytes
    localparam logic [7:0] SOF_BYTE   = 8'h68;
    localparam logic [7:0] CTRL_READ  = 8'h11;
    localparam logic [7:0] DATA_OFS   = 8'h33;
    localparam logic [7:0] EOF_BYTE   = 8'h16;
    localparam logic [7:0] BCAST_BYTE = 8'hAA;
    localparam logic [7:0] EXT_TAG    = 8'h99;
    localparam logic [7:0] LEN_EXT    = 8'h07;
    localparam logic [7:0] LEN_NORM   = 8'h04;
    localparam logic [7:0] EXT_D0     = 8'h01;
    localparam logic [7:0] EXT_D1     = 8'h00;
    localparam logic [7:0] EXT_D2     = 8'h00;
    localparam logic [7:0] EXT_D3     = 8'h07;
    localparam logic [7:0] EXT_D5     = 8'h09;

    // byte positions in the frame
    localparam logic [IDX_W-1:0] IDX_SOF       = 5'd0;
    localparam logic [IDX_W-1:0] IDX_ADDR_LAST = 5'd6;
    localparam logic [IDX_W-1:0] IDX_SOF2      = 5'd7;
    localparam logic [IDX_W-1:0] IDX_CTRL      = 5'd8;
    localparam logic [IDX_W-1:0] IDX_LEN       = 5'd9;
    localparam logic [IDX_W-1:0] IDX_DATA      = 5'd10;
    localparam logic [IDX_W-1:0] IDX_CHK_NORM  = 5'd14;
    localparam logic [IDX_W-1:0] IDX_CHK_EXT   = 5'd17;

    // one classified request, data bytes already offset
    typedef struct packed {
        logic                           ext;
        logic [DATA_MAX-1:0][BYTE_W-1:0] data;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } head_t;

    typedef struct packed {
        logic start;
        logic mid_frame;
    } back_stat_t;

endpackage

// ===== design/mrfb_front.sv =====
`timescale 1ns / 1ps

module mrfb_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [31:0]            data_id,
    output logic                   full,
    output mrfb_pkg::head_t        head,
    input  logic                   head_pop
);
    import mrfb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    req_t             req;
    req_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             accept;
    logic             take;

    // classify and pre-offset the data field
    always_comb
    begin
        req.ext = (data_id[31:24] == EXT_TAG);
        if (req.ext)
        begin
            req.data[0] = EXT_D0 + DATA_OFS;
            req.data[1] = EXT_D1 + DATA_OFS;
            req.data[2] = EXT_D2 + DATA_OFS;
            req.data[3] = EXT_D3 + DATA_OFS;
            req.data[4] = data_id[23:16] + DATA_OFS;
            req.data[5] = EXT_D5 + DATA_OFS;
            req.data[6] = data_id[7:0] + DATA_OFS;
        end
        else
        begin
            req.data[0] = data_id[7:0] + DATA_OFS;
            req.data[1] = data_id[15:8] + DATA_OFS;
            req.data[2] = data_id[23:16] + DATA_OFS;
            req.data[3] = data_id[31:24] + DATA_OFS;
            req.data[4] = '0;
            req.data[5] = '0;
            req.data[6] = '0;
        end
    end

    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign accept = push && !full;
    assign take   = head_pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (accept && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !accept)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wr_ptr_reg] <= req;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.req   = mem[rd_ptr_reg];

endmodule

// ===== design/mrfb_back.sv =====
`timescale 1ns / 1ps

module mrfb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mrfb_pkg::head_t      head,
    output logic                 head_pop,
    input  logic [47:0]          meter_address,
    input  logic                 use_broadcast_address,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           frame_byte,
    output logic                 last_byte,
    output mrfb_pkg::back_stat_t stat
);
    import mrfb_pkg::*;

    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [BYTE_W-1:0]         sum_reg, sum_next;
    logic                      out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]         out_byte_reg;
    logic                      out_last_reg;
    logic                      advance;
    logic [IDX_W-1:0]          chk_idx;
    logic [IDX_W-1:0]          last_idx;
    logic [IDX_W-1:0]          addr_off;
    logic [IDX_W-1:0]          data_off;
    logic [5:0][BYTE_W-1:0]    addr_bytes;
    logic [BYTE_W-1:0]         cur_byte;
    logic                      cur_last;

    assign advance    = head.valid && (!out_valid_reg || pop);
    assign chk_idx    = head.req.ext ? IDX_CHK_EXT : IDX_CHK_NORM;
    assign last_idx   = chk_idx + 1'b1;
    assign addr_off   = idx_reg - 1'b1;
    assign data_off   = idx_reg - IDX_DATA;
    assign addr_bytes = meter_address;
    assign cur_last   = (idx_reg == last_idx);

    always_comb
    begin
        if (idx_reg == IDX_SOF || idx_reg == IDX_SOF2)
        begin
            cur_byte = SOF_BYTE;
        end
        else if (idx_reg <= IDX_ADDR_LAST)
        begin
            cur_byte = use_broadcast_address ? BCAST_BYTE : addr_bytes[addr_off[2:0]];
        end
        else if (idx_reg == IDX_CTRL)
        begin
            cur_byte = CTRL_READ;
        end
        else if (idx_reg == IDX_LEN)
        begin
            cur_byte = head.req.ext ? LEN_EXT : LEN_NORM;
        end
        else if (idx_reg == chk_idx)
        begin
            cur_byte = sum_reg;
        end
        else if (cur_last)
        begin
            cur_byte = EOF_BYTE;
        end
        else
        begin
            cur_byte = head.req.data[data_off[2:0]];
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = cur_last ? '0 : idx_reg + 1'b1;
            // running checksum restarts on the first byte
            sum_next       = (idx_reg == IDX_SOF) ? cur_byte : sum_reg + cur_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (advance)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= cur_last;
        end
    end

    assign head_pop       = advance && cur_last;
    assign empty          = !out_valid_reg;
    assign frame_byte     = out_byte_reg;
    assign last_byte      = out_last_reg;
    assign stat.start     = advance && (idx_reg == IDX_SOF);
    assign stat.mid_frame = (idx_reg != IDX_SOF);

endmodule

// ===== design/meter_read_frame_builder.sv =====
`timescale 1ns / 1ps
// channel   | direction | handshake        | payload
// request   | in        | push / full      | data_id
// frame out | out       | empty / pop      | frame_byte, last_byte
// config    | in        | cfg_write        | cfg_index, cfg_data
//
// each item becomes a 16-byte frame (19 for the extended form), one byte per
// cycle while pop stays high, so the byte sequencer sets the item rate. a
// request queue of QUEUE_DEPTH items sits before the sequencer, so push keeps
// working while a frame is streaming or stalled, until the queue is full. a
// pushed request is stored in the queue, then its first byte is registered at
// the output. reset clears the queue, the sequencer and both config registers.

module meter_read_frame_builder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] data_id,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  frame_byte,
    output logic        last_byte,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import mrfb_pkg::*;

    `include "assert_macros.svh"

    logic [ADDR_W-1:0] meter_address_reg;
    logic              use_broadcast_reg;
    head_t             head;
    logic              head_pop;
    back_stat_t        stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meter_address_reg <= '0;
            use_broadcast_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_METER_ADDRESS: meter_address_reg <= cfg_data;
                REG_USE_BROADCAST: use_broadcast_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mrfb_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_id  (data_id),
        .full     (full),
        .head     (head),
        .head_pop (head_pop)
    );

    mrfb_back u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .head                  (head),
        .head_pop              (head_pop),
        .meter_address         (meter_address_reg),
        .use_broadcast_address (use_broadcast_reg),
        .empty                 (empty),
        .pop                   (pop),
        .frame_byte            (frame_byte),
        .last_byte             (last_byte),
        .stat                  (stat)
    );

    // closing byte is always the end marker
    `CHK_SAME(a_last_is_eof, clk, rst_n, !empty && last_byte, frame_byte == EOF_BYTE)
    // a frame opens with the start byte
    `CHK_NEXT(a_start_is_sof, clk, rst_n, stat.start, !empty && frame_byte == SOF_BYTE && !last_byte)
    // a frame in progress keeps its request at the queue head
    `CHK_SAME(a_head_held, clk, rst_n, stat.mid_frame, head.valid)

endmodule
